>>> rtl/timed_decision_release_queue_macros.svh
// Assertion macros shared by the checker of the timed decision release queue.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef TIMED_DECISION_RELEASE_QUEUE_MACROS_SVH
`define TIMED_DECISION_RELEASE_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timed decision release queue: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timed decision release queue: assertion failed");

`endif

>>> rtl/trq_pkg.sv
// Package of the timed decision release queue: sizes, result kinds, command type
// and the time classification function. Depends on nothing.
package trq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int Q_AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W      = 16;
    localparam int FRAME_W     = 12;
    localparam int SUB_W       = 4;
    localparam int CUR_FRAME_W = 10;
    localparam int TAG_W       = 16;
    localparam int ENTRY_W     = TIME_W + TAG_W;
    localparam int LIN_W       = 16;
    localparam int CLIN_W      = 14;
    localparam int DIFF_W      = 18;
    localparam int WIN_W       = 14;
    localparam int CNT_W       = 32;

    localparam int SF_WRAP = 10240;
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);

    typedef enum logic [1:0] {
        KIND_PUSH_OK   = 2'd0,
        KIND_PUSH_FULL = 2'd1,
        KIND_RELEASED  = 2'd2,
        KIND_EMPTY     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CLS_NOW    = 2'd0,
        CLS_STALE  = 2'd1,
        CLS_FUTURE = 2'd2
    } t_class;

    typedef struct packed {
        logic                   is_tick;
        logic [TIME_W-1:0]      target;
        logic [TAG_W-1:0]       tag;
        logic [CUR_FRAME_W-1:0] cur_frame;
        logic [SUB_W-1:0]       cur_sub;
        logic [CLIN_W-1:0]      cur_lin;
    } t_cmd;

    // Frame times ten plus subframe, built from shifts.
    function automatic logic [LIN_W-1:0] lin_time(input logic [FRAME_W-1:0] f,
                                                  input logic [SUB_W-1:0] s);
        return LIN_W'({f, 3'b000}) + LIN_W'({f, 1'b0}) + LIN_W'(s);
    endfunction

    function automatic logic [Q_AW-1:0] next_idx(input logic [Q_AW-1:0] idx);
        return (idx == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic t_class classify(input logic [TIME_W-1:0]      target,
                                        input logic [CUR_FRAME_W-1:0] cf,
                                        input logic [SUB_W-1:0]       cs,
                                        input logic [CLIN_W-1:0]      clin,
                                        input logic [WIN_W-1:0]       window);
        logic [FRAME_W-1:0]       f;
        logic [SUB_W-1:0]         s;
        logic [FRAME_W-1:0]       fcur;
        logic [LIN_W-1:0]         tlin;
        logic signed [DIFF_W-1:0] d_late;
        logic signed [DIFF_W-1:0] d_early;
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] win_s;
        t_class                   cls;
        f       = target[TIME_W-1:SUB_W];
        s       = target[SUB_W-1:0];
        fcur    = FRAME_W'(cf);
        tlin    = lin_time(f, s);
        d_late  = $signed(DIFF_W'(tlin)) - $signed(DIFF_W'(clin));
        d_early = $signed(DIFF_W'(SF_WRAP)) + d_late;
        d       = (f > fcur) ? d_late : d_early;
        win_s   = $signed(DIFF_W'(window));
        if (f == fcur && s == cs) begin
            cls = CLS_NOW;
        end else if (f == fcur) begin
            cls = (s < cs) ? CLS_STALE : CLS_FUTURE;
        end else begin
            cls = (d > win_s) ? CLS_STALE : CLS_FUTURE;
        end
        return cls;
    endfunction

endpackage

>>> rtl/timed_decision_release_queue.sv
// Top level of the timed decision release queue: front end, command queue and
// back end. Depends on trq_pkg, trq_front and trq_back.
//
// Items enter on i_start while o_busy is low. With i_mode low an item pushes
// the decision i_decision_tag for time i_target_sfn_sf into a 16-entry queue;
// with i_mode high it is a subframe tick at i_cur_frame/i_cur_subframe.
// Each item gives exactly one result, shown for one cycle while o_valid is
// high: o_kind, o_released_tag, o_decision_count and o_missed_count.
// A push result, and a tick result on an empty queue, come from the idle state.
// Any other tick result comes from the evaluate state, passing through the read
// state for each stale head dropped while more heads remain behind it, because
// each further head needs a registered read of the decision memory.
// A two-entry command queue lets the next item be taken while the back end
// works, so pushes sustain one per cycle until o_busy rises when it is full.
// i_cfg_we writes i_cfg_wdata to the look-ahead window; the user must write it
// only while idle, as the block does not enforce it. Synchronous reset empties
// the queue, clears both counters, sets the window to 10 and drops any pending
// result. The receiver cannot stall, so every result is taken when it is shown.
module timed_decision_release_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_mode,
    input  logic [trq_pkg::TIME_W-1:0]      i_target_sfn_sf,
    input  logic [trq_pkg::TAG_W-1:0]       i_decision_tag,
    input  logic [trq_pkg::CUR_FRAME_W-1:0] i_cur_frame,
    input  logic [trq_pkg::SUB_W-1:0]       i_cur_subframe,
    input  logic                            i_cfg_we,
    input  logic [trq_pkg::WIN_W-1:0]       i_cfg_wdata,
    output logic                            o_valid,
    output logic [1:0]                      o_kind,
    output logic [trq_pkg::TAG_W-1:0]       o_released_tag,
    output logic [trq_pkg::CNT_W-1:0]       o_decision_count,
    output logic [trq_pkg::CNT_W-1:0]       o_missed_count
);

    logic          cmd_valid;
    logic          cmd_pop;
    trq_pkg::t_cmd cmd;

    trq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_mode          (i_mode),
        .i_target_sfn_sf (i_target_sfn_sf),
        .i_decision_tag  (i_decision_tag),
        .i_cur_frame     (i_cur_frame),
        .i_cur_subframe  (i_cur_subframe),
        .i_cmd_pop       (cmd_pop),
        .o_busy          (o_busy),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd)
    );

    trq_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_valid),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_cmd_pop        (cmd_pop),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_released_tag   (o_released_tag),
        .o_decision_count (o_decision_count),
        .o_missed_count   (o_missed_count)
    );

endmodule

>>> rtl/trq_front.sv
// Front end of the timed decision release queue: accepts items, tags pushes
// and ticks and holds them in a two-entry command queue. Depends on trq_pkg.
module trq_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_mode,
    input  logic [trq_pkg::TIME_W-1:0]      i_target_sfn_sf,
    input  logic [trq_pkg::TAG_W-1:0]       i_decision_tag,
    input  logic [trq_pkg::CUR_FRAME_W-1:0] i_cur_frame,
    input  logic [trq_pkg::SUB_W-1:0]       i_cur_subframe,
    input  logic                            i_cmd_pop,
    output logic                            o_busy,
    output logic                            o_cmd_valid,
    output trq_pkg::t_cmd                   o_cmd
);

    trq_pkg::t_cmd r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;
    trq_pkg::t_cmd cmd_in;
    logic [trq_pkg::LIN_W-1:0] cur_lin;

    assign o_busy      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign push        = i_start && !o_busy;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        cur_lin          = trq_pkg::lin_time(trq_pkg::FRAME_W'(i_cur_frame), i_cur_subframe);
        cmd_in.is_tick   = i_mode;
        cmd_in.target    = i_target_sfn_sf;
        cmd_in.tag       = i_decision_tag;
        cmd_in.cur_frame = i_cur_frame;
        cmd_in.cur_sub   = i_cur_subframe;
        cmd_in.cur_lin   = cur_lin[trq_pkg::CLIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

>>> rtl/trq_back.sv
// Back end of the timed decision release queue: decision memory, head walker,
// counters, window register and result strobe. Depends on trq_pkg.
module trq_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  trq_pkg::t_cmd                i_cmd,
    input  logic                         i_cfg_we,
    input  logic [trq_pkg::WIN_W-1:0]    i_cfg_wdata,
    output logic                         o_cmd_pop,
    output logic                         o_valid,
    output logic [1:0]                   o_kind,
    output logic [trq_pkg::TAG_W-1:0]    o_released_tag,
    output logic [trq_pkg::CNT_W-1:0]    o_decision_count,
    output logic [trq_pkg::CNT_W-1:0]    o_missed_count
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EVAL = 3'b100
    } t_state;

    logic [trq_pkg::ENTRY_W-1:0] r_mem [trq_pkg::QUEUE_DEPTH];
    logic [trq_pkg::ENTRY_W-1:0] r_rd_data;

    t_state                      r_state, n_state;
    logic [trq_pkg::Q_AW-1:0]    r_head, n_head;
    logic [trq_pkg::Q_AW-1:0]    r_tail, n_tail;
    logic [trq_pkg::FILL_W-1:0]  r_fill, n_fill;
    logic [trq_pkg::CNT_W-1:0]   r_consumed, n_consumed;
    logic [trq_pkg::CNT_W-1:0]   r_missed, n_missed;
    logic [trq_pkg::WIN_W-1:0]   r_window;
    logic                        r_valid, n_valid;
    trq_pkg::t_kind              r_kind, n_kind;
    logic [trq_pkg::TAG_W-1:0]   r_tag, n_tag;
    trq_pkg::t_cmd               r_cur, n_cur;
    logic                        mem_we;
    trq_pkg::t_class             cls;

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_released_tag   = r_tag;
    assign o_decision_count = r_consumed;
    assign o_missed_count   = r_missed;

    always_comb begin
        cls = trq_pkg::classify(r_rd_data[trq_pkg::ENTRY_W-1:trq_pkg::TAG_W],
                                r_cur.cur_frame, r_cur.cur_sub, r_cur.cur_lin, r_window);
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_consumed = r_consumed;
        n_missed   = r_missed;
        n_valid    = 1'b0;
        n_kind     = r_kind;
        n_tag      = r_tag;
        n_cur      = r_cur;
        mem_we     = 1'b0;
        o_cmd_pop  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_tag     = '0;
                    if (!i_cmd.is_tick) begin
                        n_valid = 1'b1;
                        if (r_fill == trq_pkg::FILL_W'(trq_pkg::QUEUE_DEPTH)) begin
                            n_kind = trq_pkg::KIND_PUSH_FULL;
                        end else begin
                            mem_we = 1'b1;
                            n_tail = trq_pkg::next_idx(r_tail);
                            n_fill = r_fill + 1'b1;
                            n_kind = trq_pkg::KIND_PUSH_OK;
                        end
                    end else begin
                        n_cur = i_cmd;
                        if (r_fill == '0) begin
                            n_valid = 1'b1;
                            n_kind  = trq_pkg::KIND_EMPTY;
                        end else begin
                            n_state = ST_EVAL;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                case (cls)
                    trq_pkg::CLS_NOW: begin
                        n_head     = trq_pkg::next_idx(r_head);
                        n_fill     = r_fill - 1'b1;
                        n_consumed = r_consumed + 1'b1;
                        n_valid    = 1'b1;
                        n_kind     = trq_pkg::KIND_RELEASED;
                        n_tag      = r_rd_data[trq_pkg::TAG_W-1:0];
                        n_state    = ST_IDLE;
                    end
                    trq_pkg::CLS_STALE: begin
                        n_head     = trq_pkg::next_idx(r_head);
                        n_fill     = r_fill - 1'b1;
                        n_consumed = r_consumed + 1'b1;
                        n_missed   = r_missed + 1'b1;
                        if (r_fill == trq_pkg::FILL_W'(1)) begin
                            n_valid = 1'b1;
                            n_kind  = trq_pkg::KIND_EMPTY;
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_READ;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_kind  = trq_pkg::KIND_EMPTY;
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_consumed <= '0;
            r_missed   <= '0;
            r_valid    <= 1'b0;
            r_window   <= trq_pkg::WIN_RESET;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_consumed <= n_consumed;
            r_missed   <= n_missed;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_tag  <= n_tag;
        r_cur  <= n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= {i_cmd.target, i_cmd.tag};
        end
        r_rd_data <= r_mem[r_head];
    end

endmodule

>>> rtl/trq_checker.sv
// Port-level checker for the timed decision release queue and its bind.
// Depends on trq_pkg and timed_decision_release_queue_macros.svh.
`include "timed_decision_release_queue_macros.svh"

module trq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_busy,
    input logic                            o_valid,
    input logic [1:0]                      o_kind,
    input logic [trq_pkg::TAG_W-1:0]       o_released_tag,
    input logic [trq_pkg::CNT_W-1:0]       o_decision_count,
    input logic [trq_pkg::CNT_W-1:0]       o_missed_count
);

    `TRQ_ASSERT_IMPL(a_tag_zero_unless_released, i_clk, i_rst_n,
        o_valid && o_kind != trq_pkg::KIND_RELEASED, o_released_tag == '0)
    `TRQ_ASSERT_IMPL(a_release_counts, i_clk, i_rst_n,
        o_valid && o_kind == trq_pkg::KIND_RELEASED,
        o_decision_count != $past(o_decision_count))
    `TRQ_ASSERT_IMPL(a_miss_is_consumed, i_clk, i_rst_n,
        o_missed_count != $past(o_missed_count),
        o_decision_count != $past(o_decision_count))
    `TRQ_ASSERT_IMPL(a_reset_clean, i_clk, i_rst_n, $rose(i_rst_n),
        !o_valid && !o_busy && o_decision_count == '0 && o_missed_count == '0)

endmodule

bind timed_decision_release_queue trq_checker u_trq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_busy           (o_busy),
    .o_valid          (o_valid),
    .o_kind           (o_kind),
    .o_released_tag   (o_released_tag),
    .o_decision_count (o_decision_count),
    .o_missed_count   (o_missed_count)
);

>>> bench/tb_timed_decision_release_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench of timed_decision_release_queue: directed and random pushes and
// subframe ticks, checked against a scoreboard class. Depends on trq_pkg and the RTL top.
module tb_timed_decision_release_queue;

    localparam bit MODE_PUSH = 1'b0;
    localparam bit MODE_TICK = 1'b1;
    localparam int SF_PER_FRAME = 10;

    typedef struct {
        trq_pkg::t_kind kind;
        logic [15:0]    tag;
        logic [31:0]    dcount;
        logic [31:0]    mcount;
    } t_outcome;

    class release_scoreboard;
        bit [31:0]   decision_store [trq_pkg::QUEUE_DEPTH];
        int          head;
        int          tail;
        int          fill;
        bit [31:0]   consumed;
        bit [31:0]   missed;
        bit [13:0]   window;
        t_outcome    pending_outcomes [$];
        int          fail_count;
        int          mismatch_count;

        function new();
            head = 0;
            tail = 0;
            fill = 0;
            consumed = 0;
            missed = 0;
            window = 14'd10;
            fail_count = 0;
            mismatch_count = 0;
        endfunction

        function trq_pkg::t_class time_class(logic [15:0] target, logic [9:0] cf,
                                             logic [3:0] cs);
            int f;
            int s;
            int fc;
            int sc;
            int d;
            f  = target[15:4];
            s  = target[3:0];
            fc = cf;
            sc = cs;
            if (f == fc && s == sc) return trq_pkg::CLS_NOW;
            if (f == fc) return (s < sc) ? trq_pkg::CLS_STALE : trq_pkg::CLS_FUTURE;
            if (f > fc) begin
                d = (f * SF_PER_FRAME + s) - (fc * SF_PER_FRAME + sc);
            end else begin
                d = trq_pkg::SF_WRAP - (fc * SF_PER_FRAME + sc) + (f * SF_PER_FRAME + s);
            end
            return (d > int'(window)) ? trq_pkg::CLS_STALE : trq_pkg::CLS_FUTURE;
        endfunction

        function void note_item(bit mode, logic [15:0] target, logic [15:0] tag,
                                logic [9:0] cf, logic [3:0] cs);
            t_outcome        o;
            bit [31:0]       e;
            trq_pkg::t_class c;
            bit              done;
            o.kind = trq_pkg::KIND_EMPTY;
            o.tag  = '0;
            if (mode == MODE_PUSH) begin
                if (fill >= trq_pkg::QUEUE_DEPTH) begin
                    o.kind = trq_pkg::KIND_PUSH_FULL;
                end else begin
                    decision_store[tail] = {target, tag};
                    tail = (tail + 1) % trq_pkg::QUEUE_DEPTH;
                    fill++;
                    o.kind = trq_pkg::KIND_PUSH_OK;
                end
            end else begin
                done = 1'b0;
                while (fill > 0 && !done) begin
                    e = decision_store[head];
                    c = time_class(e[31:16], cf, cs);
                    if (c == trq_pkg::CLS_FUTURE) begin
                        done = 1'b1;
                    end else begin
                        head = (head + 1) % trq_pkg::QUEUE_DEPTH;
                        fill--;
                        consumed++;
                        if (c == trq_pkg::CLS_NOW) begin
                            o.kind = trq_pkg::KIND_RELEASED;
                            o.tag  = e[15:0];
                            done   = 1'b1;
                        end else begin
                            missed++;
                        end
                    end
                end
            end
            o.dcount = consumed;
            o.mcount = missed;
            pending_outcomes.push_back(o);
        endfunction

        function void check_result(logic [1:0] kind, logic [15:0] tag,
                                   logic [31:0] dcount, logic [31:0] mcount);
            t_outcome o;
            if (pending_outcomes.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result with no item waiting, kind %0d tag %h", $realtime,
                             kind, tag);
                end
                return;
            end
            o = pending_outcomes.pop_front();
            if (kind !== o.kind || tag !== o.tag || dcount !== o.dcount ||
                    mcount !== o.mcount) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display({"%0t: mismatch kind %0d/%0d tag %h/%h ",
                              "decisions %0d/%0d missed %0d/%0d"},
                             $realtime, o.kind, kind, o.tag, tag, o.dcount, dcount,
                             o.mcount, mcount);
                end
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_start;
    logic                            o_busy;
    logic                            i_mode;
    logic [trq_pkg::TIME_W-1:0]      i_target_sfn_sf;
    logic [trq_pkg::TAG_W-1:0]       i_decision_tag;
    logic [trq_pkg::CUR_FRAME_W-1:0] i_cur_frame;
    logic [trq_pkg::SUB_W-1:0]       i_cur_subframe;
    logic                            i_cfg_we;
    logic [trq_pkg::WIN_W-1:0]       i_cfg_wdata;
    logic                            o_valid;
    logic [1:0]                      o_kind;
    logic [trq_pkg::TAG_W-1:0]       o_released_tag;
    logic [trq_pkg::CNT_W-1:0]       o_decision_count;
    logic [trq_pkg::CNT_W-1:0]       o_missed_count;

    release_scoreboard sb;
    int                now_lin;

    timed_decision_release_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_mode           (i_mode),
        .i_target_sfn_sf  (i_target_sfn_sf),
        .i_decision_tag   (i_decision_tag),
        .i_cur_frame      (i_cur_frame),
        .i_cur_subframe   (i_cur_subframe),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_released_tag   (o_released_tag),
        .o_decision_count (o_decision_count),
        .o_missed_count   (o_missed_count)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_result(o_kind, o_released_tag, o_decision_count, o_missed_count);
            end
            if (i_start && !o_busy) begin
                sb.note_item(i_mode, i_target_sfn_sf, i_decision_tag, i_cur_frame,
                             i_cur_subframe);
            end
        end
    end

    task automatic send_item(input bit mode, input logic [15:0] target, input logic [15:0] tag,
                             input logic [9:0] cf, input logic [3:0] cs);
        @(negedge i_clk);
        i_start         = 1'b1;
        i_mode          = mode;
        i_target_sfn_sf = target;
        i_decision_tag  = tag;
        i_cur_frame     = cf;
        i_cur_subframe  = cs;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic push_at(input logic [11:0] f, input logic [3:0] s, input logic [15:0] tag);
        send_item(MODE_PUSH, {f, s}, tag, 10'($urandom), 4'($urandom));
    endtask

    task automatic tick_at(input logic [9:0] cf, input logic [3:0] cs);
        send_item(MODE_TICK, 16'($urandom), 16'($urandom), cf, cs);
    endtask

    task automatic pause_sender(input int n);
        @(negedge i_clk);
        i_start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_queue();
        @(negedge i_clk);
        i_start = 1'b0;
        while (sb.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [13:0] value);
        drain_queue();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.window   = value;
    endtask

    task automatic run_phase(input int n_items, input bit gaps);
        int k;
        int pick;
        int off;
        int tl;
        bit quiet;
        quiet = 1'b0;
        for (k = 0; k < n_items; k++) begin
            if (k % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (gaps && !quiet && $urandom_range(0, 99) < 20) begin
                pause_sender($urandom_range(1, 17));
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                off = $urandom_range(0, 24) - 5;
                tl  = (now_lin + off + trq_pkg::SF_WRAP) % trq_pkg::SF_WRAP;
                push_at(12'(tl / SF_PER_FRAME), 4'(tl % SF_PER_FRAME), 16'($urandom));
            end else if (pick < 88) begin
                if ($urandom_range(0, 49) == 0) begin
                    now_lin = $urandom_range(0, trq_pkg::SF_WRAP - 1);
                end else begin
                    now_lin = (now_lin + $urandom_range(0, 2)) % trq_pkg::SF_WRAP;
                end
                tick_at(10'(now_lin / SF_PER_FRAME), 4'(now_lin % SF_PER_FRAME));
            end else if (pick < 94) begin
                send_item(MODE_PUSH, 16'($urandom), 16'($urandom), 10'($urandom),
                          4'($urandom));
            end else begin
                tick_at(10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
            end
        end
    endtask

    initial begin
        int k;
        sb              = new();
        now_lin         = 0;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_mode          = 1'b0;
        i_target_sfn_sf = '0;
        i_decision_tag  = '0;
        i_cur_frame     = '0;
        i_cur_subframe  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items under the reset window.
        tick_at(10'd0, 4'd0);
        push_at(12'hFFF, 4'hF, 16'h0000);
        tick_at(10'd1023, 4'd9);
        push_at(12'd5, 4'd2, 16'h0001);
        push_at(12'd5, 4'd8, 16'h0002);
        tick_at(10'd5, 4'd7);
        tick_at(10'd5, 4'd8);
        push_at(12'd0, 4'd2, 16'hFFFF);
        push_at(12'd11, 4'd0, 16'h5A5A);
        tick_at(10'd1023, 4'd8);
        tick_at(10'd0, 4'd2);
        tick_at(10'd10, 4'd15);
        tick_at(10'd11, 4'd0);
        for (k = 0; k <= trq_pkg::QUEUE_DEPTH; k++) begin
            push_at(12'd0, 4'd0, 16'(k));
        end
        tick_at(10'd500, 4'd0);

        write_window(14'd0);
        run_phase(130, 1'b1);
        write_window(14'd10240);
        run_phase(130, 1'b1);
        write_window(14'd8191);
        run_phase(130, 1'b1);
        write_window(14'($urandom_range(0, 10240)));
        run_phase(130, 1'b1);
        write_window(14'd10);
        run_phase(130, 1'b0);

        drain_queue();
        repeat (40) @(posedge i_clk);
        if (sb.pending_outcomes.size() != 0) sb.fail_count++;
        if (sb.fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
